@@ hw/rtl/tbpp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpp_pkg
// Shared types, constants and mode decode for the three band pixel packer.
// ----------------------------------------------------------------------------
package tbpp_pkg;

  localparam int TBPP_BANDS      = 3;
  localparam int DEPTH_W         = 5;
  localparam int STRIDE_W        = 4;
  localparam int SAMPLE_W        = 16;
  localparam int PIX_BYTES       = 8;
  localparam int PIX_W           = 8 * PIX_BYTES;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 5;
  localparam int SUM_W           = 7;
  localparam int SUB_BYTE_MAX    = 8;

  localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 5'd8;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_FIRST     = 3'd0,
    REG_DEPTH_SECOND    = 3'd1,
    REG_DEPTH_THIRD     = 3'd2,
    REG_FILL_MS_FIRST   = 3'd3,
    REG_SAMPLE_MS_FIRST = 3'd4,
    REG_BAND_REVERSE    = 3'd5,
    REG_PIXEL_STRIDE    = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_ERR,
    MODE_16,
    MODE_8,
    MODE_4,
    MODE_SUB
  } pack_mode_t;

  typedef logic [DEPTH_W-1:0] depth_t;

  typedef struct packed {
    pack_mode_t                 mode;
    logic                       fill_ms_first;
    logic                       sample_ms_first;
    depth_t [TBPP_BANDS-1:0]    depth;
  } lane_ctrl_t;

  function automatic pack_mode_t decode_mode(input depth_t d0, input depth_t d1,
                                             input depth_t d2);
    logic [SUM_W-1:0] sum;
    logic             bad;
    pack_mode_t       m;
    sum = SUM_W'(d0) + SUM_W'(d1) + SUM_W'(d2);
    bad = (d0 == '0) || (d1 == '0) || (d2 == '0) ||
          (d0 > depth_t'(SAMPLE_W)) || (d1 > depth_t'(SAMPLE_W)) ||
          (d2 > depth_t'(SAMPLE_W));
    if (bad) begin
      m = MODE_ERR;
    end else if (d0 == 5'd16 && d1 == 5'd16 && d2 == 5'd16) begin
      m = MODE_16;
    end else if (d0 == 5'd8 && d1 == 5'd8 && d2 == 5'd8) begin
      m = MODE_8;
    end else if (d0 == 5'd4 && d1 == 5'd4 && d2 == 5'd4) begin
      m = MODE_4;
    end else if (sum <= SUM_W'(SUB_BYTE_MAX)) begin
      m = MODE_SUB;
    end else begin
      m = MODE_ERR;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/tbpp_lane.sv @@
// ----------------------------------------------------------------------------
// tbpp_lane
// Places one band sample into its byte/bit position for the active mode.
// ----------------------------------------------------------------------------
module tbpp_lane import tbpp_pkg::*; #(
  parameter int BAND_COUNT = TBPP_BANDS,
  parameter int LANE_IDX   = 0
) (
  input  logic                clk,
  input  logic                load,
  input  lane_ctrl_t          ctrl,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [PIX_W-1:0]    lane_bytes
);

  logic [PIX_W-1:0] lane_bytes_r;
  logic [PIX_W-1:0] lane_bytes_nxt;
  logic [SUM_W-1:0] pre_sum;
  logic [SUM_W-1:0] post_sum;
  logic [2:0]       sub_shift;
  logic [8:0]       sub_mask;
  logic [7:0]       sub_field;
  logic [15:0]      word16;
  logic [3:0]       nib_pos;

  always_comb begin
    pre_sum  = '0;
    post_sum = '0;
    for (int j = 0; j < BAND_COUNT; j++) begin
      if (j <= LANE_IDX) begin
        pre_sum = pre_sum + SUM_W'(ctrl.depth[j]);
      end else begin
        post_sum = post_sum + SUM_W'(ctrl.depth[j]);
      end
    end
    if (ctrl.fill_ms_first) begin
      sub_shift = 3'(SUM_W'(SUB_BYTE_MAX) - pre_sum);
    end else begin
      sub_shift = post_sum[2:0];
    end
    sub_mask  = (9'd1 << ctrl.depth[LANE_IDX]) - 9'd1;
    sub_field = sample[7:0] & sub_mask[7:0];

    word16 = ctrl.sample_ms_first ? {sample[7:0], sample[15:8]} : sample;

    // nibble slot within the first two bytes
    if (ctrl.fill_ms_first) begin
      nib_pos = (LANE_IDX == 0) ? 4'd1 : (LANE_IDX == 1) ? 4'd0 : 4'd3;
    end else begin
      nib_pos = 4'(LANE_IDX);
    end

    case (ctrl.mode)
      MODE_16:  lane_bytes_nxt = PIX_W'(word16) << (16 * LANE_IDX);
      MODE_8:   lane_bytes_nxt = PIX_W'(sample[7:0]) << (8 * LANE_IDX);
      MODE_4:   lane_bytes_nxt = PIX_W'(sample[3:0]) << {nib_pos, 2'b00};
      MODE_SUB: lane_bytes_nxt = PIX_W'(sub_field) << sub_shift;
      default:  lane_bytes_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane_bytes_r <= lane_bytes_nxt;
    end
  end

  assign lane_bytes = lane_bytes_r;

endmodule

@@ hw/rtl/tbpp_merge.sv @@
// ----------------------------------------------------------------------------
// tbpp_merge
// Combines the lane bytes, trims to the pixel stride and registers the result.
// ----------------------------------------------------------------------------
module tbpp_merge import tbpp_pkg::*; #(
  parameter int BAND_COUNT = TBPP_BANDS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              valid_in,
  input  logic                              err_in,
  input  logic                              line_end_in,
  input  logic [BAND_COUNT-1:0][PIX_W-1:0]  lane_bytes,
  input  logic [STRIDE_W-1:0]               stride,
  output logic                              out_valid,
  output logic [PIX_W-1:0]                  out_packed_bytes,
  output logic [STRIDE_W-1:0]               out_byte_count,
  output logic                              out_depth_error,
  output logic                              out_line_end_out
);

  logic                valid_r;
  logic [PIX_W-1:0]    bytes_r, bytes_nxt;
  logic [STRIDE_W-1:0] count_r, count_nxt;
  logic                err_r;
  logic                line_end_r;
  logic [PIX_W-1:0]    merged;

  always_comb begin
    if (stride == '0) begin
      count_nxt = STRIDE_W'(1);
    end else if (stride > STRIDE_W'(PIX_BYTES)) begin
      count_nxt = STRIDE_W'(PIX_BYTES);
    end else begin
      count_nxt = stride;
    end
    merged = '0;
    for (int k = 0; k < BAND_COUNT; k++) begin
      merged = merged | lane_bytes[k];
    end
    for (int b = 0; b < PIX_BYTES; b++) begin
      bytes_nxt[8*b +: 8] = (STRIDE_W'(b) < count_nxt && !err_in) ? merged[8*b +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in) begin
      bytes_r    <= bytes_nxt;
      count_r    <= count_nxt;
      err_r      <= err_in;
      line_end_r <= line_end_in;
    end
  end

  assign out_valid        = valid_r;
  assign out_packed_bytes = bytes_r;
  assign out_byte_count   = count_r;
  assign out_depth_error  = err_r;
  assign out_line_end_out = line_end_r;

endmodule

@@ hw/rtl/triple_band_pixel_packer.sv @@
// ----------------------------------------------------------------------------
// triple_band_pixel_packer
// Band interleaved by pixel packer: three band lanes and a merge stage.
// ----------------------------------------------------------------------------
// channel   ports                         handshake
// request   in_band_*, in_line_end_in     start & !busy
// result    out_packed_bytes ... out_*    out_valid, one cycle
// config    cfg_index, cfg_wdata          cfg_we
//
// one request per cycle; each result passes the lane register and then the
// merge output register
// busy stays low; the receiver cannot stall the result
// synchronous active-low reset restores register defaults and drops valids
// ----------------------------------------------------------------------------
module triple_band_pixel_packer import tbpp_pkg::*; #(
  parameter int BAND_COUNT = TBPP_BANDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [SAMPLE_W-1:0]   in_band_zero,
  input  logic [SAMPLE_W-1:0]   in_band_one,
  input  logic [SAMPLE_W-1:0]   in_band_two,
  input  logic                  in_line_end_in,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_packed_bytes,
  output logic [STRIDE_W-1:0]   out_byte_count,
  output logic                  out_depth_error,
  output logic                  out_line_end_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  depth_t              depth_first_r, depth_second_r, depth_third_r;
  logic                fill_ms_first_r, sample_ms_first_r, band_reverse_r;
  logic [STRIDE_W-1:0] stride_r;

  logic                s1_valid_r, s1_err_r, s1_line_end_r;
  logic                accept;
  lane_ctrl_t          ctrl;
  logic [BAND_COUNT-1:0][SAMPLE_W-1:0] bands;
  logic [BAND_COUNT-1:0][SAMPLE_W-1:0] placed;
  logic [BAND_COUNT-1:0][PIX_W-1:0]    lane_bytes;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_first_r     <= DEPTH_RESET;
      depth_second_r    <= DEPTH_RESET;
      depth_third_r     <= DEPTH_RESET;
      fill_ms_first_r   <= 1'b1;
      sample_ms_first_r <= 1'b1;
      band_reverse_r    <= 1'b0;
      stride_r          <= STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH_FIRST:     depth_first_r     <= cfg_wdata;
        REG_DEPTH_SECOND:    depth_second_r    <= cfg_wdata;
        REG_DEPTH_THIRD:     depth_third_r     <= cfg_wdata;
        REG_FILL_MS_FIRST:   fill_ms_first_r   <= cfg_wdata[0];
        REG_SAMPLE_MS_FIRST: sample_ms_first_r <= cfg_wdata[0];
        REG_BAND_REVERSE:    band_reverse_r    <= cfg_wdata[0];
        REG_PIXEL_STRIDE:    stride_r          <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bands[0] = in_band_zero;
    bands[1] = in_band_one;
    bands[2] = in_band_two;
    for (int k = 0; k < BAND_COUNT; k++) begin
      placed[k] = band_reverse_r ? bands[BAND_COUNT-1-k] : bands[k];
    end
    ctrl.mode            = decode_mode(depth_first_r, depth_second_r, depth_third_r);
    ctrl.fill_ms_first   = fill_ms_first_r;
    ctrl.sample_ms_first = sample_ms_first_r;
    ctrl.depth[0]        = depth_first_r;
    ctrl.depth[1]        = depth_second_r;
    ctrl.depth[2]        = depth_third_r;
  end

  for (genvar g = 0; g < BAND_COUNT; g++) begin : g_lane
    tbpp_lane #(
      .BAND_COUNT (BAND_COUNT),
      .LANE_IDX   (g)
    ) u_lane (
      .clk        (clk),
      .load       (accept),
      .ctrl       (ctrl),
      .sample     (placed[g]),
      .lane_bytes (lane_bytes[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err_r      <= (ctrl.mode == MODE_ERR);
      s1_line_end_r <= in_line_end_in;
    end
  end

  tbpp_merge #(
    .BAND_COUNT (BAND_COUNT)
  ) u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid_in         (s1_valid_r),
    .err_in           (s1_err_r),
    .line_end_in      (s1_line_end_r),
    .lane_bytes       (lane_bytes),
    .stride           (stride_r),
    .out_valid        (out_valid),
    .out_packed_bytes (out_packed_bytes),
    .out_byte_count   (out_byte_count),
    .out_depth_error  (out_depth_error),
    .out_line_end_out (out_line_end_out)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid) else $error("result missing two cycles after request");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count != '0 && out_byte_count <= STRIDE_W'(PIX_BYTES)))
    else $error("byte count out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_depth_error) |-> (out_packed_bytes == '0))
    else $error("error result carries data");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s1_valid_r)) else $error("result without request");
`endif

endmodule

@@ dv/triple_band_pixel_packer_tb.sv @@
// ----------------------------------------------------------------------------
// triple_band_pixel_packer_tb
// Self-checking bench for the three band pixel packer. Pixels are sent from a
// queue with random gaps. Each accepted pixel is packed by a behavioral
// predictor built from the current register shadow. The monitor compares
// every result strobe field by field against the oldest prediction.
// Registers are rewritten only with the block drained. Directed phases cover
// each packing mode, band reversal, byte order, fill order, stride clamping
// and unsupported depths. Random phases follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triple_band_pixel_packer_tb;
  import tbpp_pkg::*;

  typedef struct {
    logic [SAMPLE_W-1:0] band_zero;
    logic [SAMPLE_W-1:0] band_one;
    logic [SAMPLE_W-1:0] band_two;
    logic                line_end;
    int unsigned         gap;
  } pixel_req_t;

  typedef struct {
    logic [PIX_W-1:0]    bytes;
    logic [STRIDE_W-1:0] count;
    logic                err;
    logic                line_end;
  } pixel_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [SAMPLE_W-1:0]   in_band_zero = '0;
  logic [SAMPLE_W-1:0]   in_band_one = '0;
  logic [SAMPLE_W-1:0]   in_band_two = '0;
  logic                  in_line_end_in = 1'b0;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_packed_bytes;
  logic [STRIDE_W-1:0]   out_byte_count;
  logic                  out_depth_error;
  logic                  out_line_end_out;
  logic                  cfg_we = 1'b0;
  reg_idx_t              cfg_index = REG_DEPTH_FIRST;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  depth_t                cfg_depth [TBPP_BANDS] = '{DEPTH_RESET, DEPTH_RESET, DEPTH_RESET};
  logic                  cfg_fill_ms = 1'b1;
  logic                  cfg_sample_ms = 1'b1;
  logic                  cfg_reverse = 1'b0;
  logic [STRIDE_W-1:0]   cfg_stride = STRIDE_RESET;

  pixel_req_t            pixels_to_send [$];
  pixel_res_t            packed_due [$];
  pixel_req_t            cur_pixel;
  int unsigned           gap_waited = 0;
  int unsigned           pixels_sent = 0;
  int                    mismatch_count = 0;

  triple_band_pixel_packer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_band_zero     (in_band_zero),
    .in_band_one      (in_band_one),
    .in_band_two      (in_band_two),
    .in_line_end_in   (in_line_end_in),
    .out_valid        (out_valid),
    .out_packed_bytes (out_packed_bytes),
    .out_byte_count   (out_byte_count),
    .out_depth_error  (out_depth_error),
    .out_line_end_out (out_line_end_out),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic pixel_res_t pack_pixel(input pixel_req_t px);
    logic [SAMPLE_W-1:0] s [TBPP_BANDS];
    int unsigned         d [TBPP_BANDS];
    int unsigned         sh [TBPP_BANDS];
    int unsigned         stride;
    int unsigned         sum;
    logic [7:0]          sub;
    logic [PIX_W-1:0]    acc;
    logic                err;
    pixel_res_t          res;
    stride = cfg_stride;
    if (stride == 0) stride = 1;
    if (stride > 8) stride = 8;
    s[0] = cfg_reverse ? px.band_two : px.band_zero;
    s[1] = px.band_one;
    s[2] = cfg_reverse ? px.band_zero : px.band_two;
    for (int k = 0; k < TBPP_BANDS; k++) d[k] = cfg_depth[k];
    sum = d[0] + d[1] + d[2];
    acc = '0;
    err = 1'b0;
    sub = '0;
    if (d[0] == 0 || d[1] == 0 || d[2] == 0 || d[0] > 16 || d[1] > 16 || d[2] > 16) begin
      err = 1'b1;
    end else if (d[0] == 16 && d[1] == 16 && d[2] == 16) begin
      for (int k = 0; k < TBPP_BANDS; k++) begin
        acc[16*k +: 8]   = cfg_sample_ms ? s[k][15:8] : s[k][7:0];
        acc[16*k+8 +: 8] = cfg_sample_ms ? s[k][7:0] : s[k][15:8];
      end
    end else if (d[0] == 8 && d[1] == 8 && d[2] == 8) begin
      for (int k = 0; k < TBPP_BANDS; k++) acc[8*k +: 8] = s[k][7:0];
    end else if (d[0] == 4 && d[1] == 4 && d[2] == 4) begin
      if (cfg_fill_ms) begin
        acc[15:0] = {s[2][3:0], 4'h0, s[0][3:0], s[1][3:0]};
      end else begin
        acc[15:0] = {4'h0, s[2][3:0], s[1][3:0], s[0][3:0]};
      end
    end else if (sum <= 8) begin
      if (cfg_fill_ms) begin
        sh[0] = 8 - d[0];
        sh[1] = 8 - d[0] - d[1];
        sh[2] = 8 - sum;
      end else begin
        sh[2] = 0;
        sh[1] = d[2];
        sh[0] = d[1] + d[2];
      end
      for (int k = 0; k < TBPP_BANDS; k++)
        sub = sub | 8'((32'(s[k]) & ((32'd1 << d[k]) - 32'd1)) << sh[k]);
      acc[7:0] = sub;
    end else begin
      err = 1'b1;
    end
    if (err) acc = '0;
    if (stride < 8) acc = acc & ((64'd1 << (8 * stride)) - 64'd1);
    res.bytes    = acc;
    res.count    = STRIDE_W'(stride);
    res.err      = err;
    res.line_end = px.line_end;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin : driver
    logic fire;
    pixel_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      gap_waited <= 0;
    end else begin
      fire = start && !busy;
      if (fire) packed_due.push_back(pack_pixel(cur_pixel));
      if (start && !fire) begin
        // hold the request
      end else if (pixels_to_send.size() == 0) begin
        start <= 1'b0;
      end else if (gap_waited < pixels_to_send[0].gap) begin
        start <= 1'b0;
        gap_waited <= gap_waited + 1;
      end else begin
        nxt = pixels_to_send.pop_front();
        cur_pixel <= nxt;
        in_band_zero <= nxt.band_zero;
        in_band_one <= nxt.band_one;
        in_band_two <= nxt.band_two;
        in_line_end_in <= nxt.line_end;
        start <= 1'b1;
        gap_waited <= 0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    pixel_res_t want;
    if (rst_n && out_valid) begin
      if (packed_due.size() == 0) begin
        $error("unexpected result, packed_bytes %h", out_packed_bytes);
        mismatch_count++;
      end else begin
        want = packed_due.pop_front();
        if (out_packed_bytes !== want.bytes) begin
          $error("packed_bytes expected %h actual %h", want.bytes, out_packed_bytes);
          mismatch_count++;
        end
        if (out_byte_count !== want.count) begin
          $error("byte_count expected %0d actual %0d", want.count, out_byte_count);
          mismatch_count++;
        end
        if (out_depth_error !== want.err) begin
          $error("depth_error expected %b actual %b", want.err, out_depth_error);
          mismatch_count++;
        end
        if (out_line_end_out !== want.line_end) begin
          $error("line_end_out expected %b actual %b", want.line_end, out_line_end_out);
          mismatch_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || start || packed_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DEPTH_FIRST:     cfg_depth[0] = val;
      REG_DEPTH_SECOND:    cfg_depth[1] = val;
      REG_DEPTH_THIRD:     cfg_depth[2] = val;
      REG_FILL_MS_FIRST:   cfg_fill_ms = val[0];
      REG_SAMPLE_MS_FIRST: cfg_sample_ms = val[0];
      REG_BAND_REVERSE:    cfg_reverse = val[0];
      REG_PIXEL_STRIDE:    cfg_stride = val[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input int unsigned d0, d1, d2, input logic fill, samp, rev,
                             input int unsigned stride);
    wait_drained();
    set_reg(REG_DEPTH_FIRST, CFG_DATA_W'(d0));
    set_reg(REG_DEPTH_SECOND, CFG_DATA_W'(d1));
    set_reg(REG_DEPTH_THIRD, CFG_DATA_W'(d2));
    set_reg(REG_FILL_MS_FIRST, CFG_DATA_W'(fill));
    set_reg(REG_SAMPLE_MS_FIRST, CFG_DATA_W'(samp));
    set_reg(REG_BAND_REVERSE, CFG_DATA_W'(rev));
    set_reg(REG_PIXEL_STRIDE, CFG_DATA_W'(stride));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_pixel(input logic [SAMPLE_W-1:0] b0, b1, b2, input logic le,
                            input int unsigned gap);
    pixel_req_t px;
    px.band_zero = b0;
    px.band_one  = b1;
    px.band_two  = b2;
    px.line_end  = le;
    px.gap       = gap;
    pixels_to_send.push_back(px);
    pixels_sent++;
  endtask

  task automatic directed_phase(input int unsigned d0, d1, d2, input logic fill, samp, rev,
                                input int unsigned stride);
    load_config(d0, d1, d2, fill, samp, rev, stride);
    push_pixel(16'h12a5, 16'h5c3e, 16'hf0c9, 1'b1, 0);
    push_pixel(16'hffff, 16'hffff, 16'hffff, 1'b0, 3);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    int unsigned d0, d1, d2, t, stride, count;
    logic quiet;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register defaults after reset
    push_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
    push_pixel(16'h12a5, 16'h5c3e, 16'hf0c9, 1'b1, 0);
    push_pixel(16'hffff, 16'hffff, 16'hffff, 1'b0, 2);

    directed_phase(16, 16, 16, 1'b1, 1'b1, 1'b0, 8);
    directed_phase(16, 16, 16, 1'b0, 1'b0, 1'b1, 6);
    directed_phase(8, 8, 8, 1'b0, 1'b0, 1'b1, 1);
    directed_phase(4, 4, 4, 1'b1, 1'b1, 1'b0, 2);
    directed_phase(4, 4, 4, 1'b0, 1'b1, 1'b1, 8);
    directed_phase(1, 1, 1, 1'b1, 1'b0, 1'b0, 1);
    directed_phase(1, 1, 6, 1'b0, 1'b1, 1'b0, 3);
    directed_phase(3, 3, 2, 1'b1, 1'b1, 1'b1, 15);
    directed_phase(0, 8, 8, 1'b1, 1'b1, 0, 0);
    directed_phase(8, 8, 4, 1'b0, 1'b0, 1'b0, 5);
    directed_phase(16, 31, 16, 1'b1, 1'b0, 1'b1, 8);

    while (pixels_sent < 975) begin
      case ($urandom_range(0, 9))
        0, 1: begin d0 = 16; d1 = 16; d2 = 16; end
        2, 3: begin d0 = 8; d1 = 8; d2 = 8; end
        4, 5: begin d0 = 4; d1 = 4; d2 = 4; end
        6, 7, 8: begin
          d0 = $urandom_range(1, 6);
          d1 = $urandom_range(1, 7 - d0);
          d2 = $urandom_range(1, 8 - d0 - d1);
          if ($urandom_range(0, 1)) begin
            t = d0; d0 = d2; d2 = t;
          end
        end
        default: begin
          d0 = $urandom_range(0, 31);
          d1 = $urandom_range(0, 31);
          d2 = $urandom_range(0, 31);
        end
      endcase
      stride = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
      load_config(d0, d1, d2, 1'($urandom()), 1'($urandom()), 1'($urandom()), stride);
      quiet = ($urandom_range(0, 3) == 0);
      count = $urandom_range(20, 60);
      repeat (count)
        push_pixel(rand_sample(), rand_sample(), rand_sample(), 1'($urandom()),
                   quiet ? 0 : $urandom_range(0, 7));
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (packed_due.size() != 0) begin
      $error("%0d results never arrived", packed_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** triple_band_pixel_packer: PASSED **");
    end else begin
      $display("** triple_band_pixel_packer: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("** triple_band_pixel_packer: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tbpp_pkg.sv
hw/rtl/tbpp_lane.sv
hw/rtl/tbpp_merge.sv
hw/rtl/triple_band_pixel_packer.sv
dv/triple_band_pixel_packer_tb.sv
